@@ sv/band_table_frequency_lookup_macros.svh @@
`ifndef BAND_TABLE_FREQUENCY_LOOKUP_MACROS_SVH
`define BAND_TABLE_FREQUENCY_LOOKUP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BTFL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BTFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/btfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package btfl_pkg;

    // field widths
    localparam int REQ_W     = 2;
    localparam int FREQ_W    = 27;
    localparam int STEP_W    = 16;
    localparam int CHAN_W    = 10;
    localparam int INDEX_W   = 5;
    localparam int TOTAL_W   = 6;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // one band table entry
    typedef struct packed {
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        logic [STEP_W-1:0] step;
        logic [CHAN_W-1:0] chan;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // remainder unit request and response
    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] dividend;
        logic [STEP_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

@@ sv/band_table_frequency_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Band table with narrowest-band lookup. Clear, append and unused request codes
// finish at once: busy stays low and o_valid pulses in the cycle after the request.
// A lookup raises busy and walks the table memory one entry at a time through read,
// check and update steps, with a remainder step between check and update for each
// band that contains the frequency and has a nonzero step when precise_step is set;
// the bit-serial remainder unit takes one dividend bit per cycle.
// o_valid then pulses from the finish state that follows the last entry's update;
// with an empty table it pulses in the next cycle. Each result shows for exactly one
// cycle and cannot be held off, so the receiver must take it when o_valid is high.
module band_table_frequency_lookup #(
    parameter int MAX_BANDS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [btfl_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [btfl_pkg::FREQ_W-1:0]    i_band_start,
    input  wire logic [btfl_pkg::FREQ_W-1:0]    i_band_end,
    input  wire logic [btfl_pkg::STEP_W-1:0]    i_step_size,
    input  wire logic [btfl_pkg::CHAN_W-1:0]    i_channel_number,
    input  wire logic [btfl_pkg::FREQ_W-1:0]    i_query_freq,
    input  wire logic                           i_precise_step,
    output logic                                o_valid,
    output logic                                o_found,
    output logic      [btfl_pkg::INDEX_W-1:0]   o_band_index,
    output logic      [btfl_pkg::CHAN_W-1:0]    o_band_channel,
    output logic                                o_table_full,
    output logic      [btfl_pkg::TOTAL_W-1:0]   o_entry_total
);

`include "band_table_frequency_lookup_macros.svh"

    localparam int IDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CNT_W = $clog2(MAX_BANDS + 1);
    localparam int EXT_W = CNT_W + btfl_pkg::TOTAL_W + btfl_pkg::INDEX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [CNT_W-1:0]                r_count;
    logic [IDX_W-1:0]                r_idx;
    logic [btfl_pkg::FREQ_W-1:0]     r_freq;
    logic                            r_precise;
    logic                            r_cand;
    logic [btfl_pkg::FREQ_W-1:0]     r_span;
    logic                            r_found;
    logic [IDX_W-1:0]                r_best_idx;
    logic [btfl_pkg::FREQ_W-1:0]     r_best_span;
    logic [btfl_pkg::CHAN_W-1:0]     r_best_chan;
    logic                            r_full;
    logic                            r_valid;

    logic                            w_accept;
    logic                            w_is_full;
    logic                            w_we;
    logic                            w_re;
    logic                            w_last;
    logic                            w_in_range;
    logic                            w_cand;
    logic                            w_better;
    btfl_pkg::t_entry                w_wentry;
    btfl_pkg::t_entry                w_rentry;
    logic [btfl_pkg::ENTRY_W-1:0]    w_rdata;
    btfl_pkg::t_mod_req              w_mod_req;
    btfl_pkg::t_mod_rsp              w_mod_rsp;
    logic [EXT_W-1:0]                w_idx_ext;
    logic [EXT_W-1:0]                w_cnt_ext;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_is_full = (r_count >= CNT_W'(MAX_BANDS));
    assign w_we      = w_accept && (i_req_type == btfl_pkg::REQ_APPEND) && !w_is_full;
    assign w_re      = (r_state == S_RD);
    assign w_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // new entry for an append
    assign w_wentry.lo   = i_band_start;
    assign w_wentry.hi   = i_band_end;
    assign w_wentry.step = i_step_size;
    assign w_wentry.chan = i_channel_number;

    // band table memory; appends happen only while idle, reads only while busy
    btfl_ram #(
        .WIDTH (btfl_pkg::ENTRY_W),
        .DEPTH (MAX_BANDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rentry = btfl_pkg::t_entry'(w_rdata);

    // containment check on the entry just read
    assign w_in_range = (r_freq >= w_rentry.lo) && (r_freq <= w_rentry.hi);
    assign w_cand     = w_in_range && !(r_precise && (w_rentry.step == '0));
    assign w_better   = r_cand && (!r_found || (r_span < r_best_span));

    // step alignment check
    assign w_mod_req.start    = (r_state == S_CHK) && w_cand && r_precise;
    assign w_mod_req.dividend = r_freq;
    assign w_mod_req.divisor  = w_rentry.step;

    btfl_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == btfl_pkg::REQ_LOOKUP) && (r_count != '0)) begin
                    n_state = S_RD;
                end
            end
            S_RD:  n_state = S_CHK;
            S_CHK: n_state = w_mod_req.start ? S_MOD : S_UPD;
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = w_last ? S_FIN : S_RD;
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (w_accept) begin
                unique case (i_req_type)
                    btfl_pkg::REQ_CLEAR: begin
                        r_count <= '0;
                        r_valid <= 1'b1;
                    end
                    btfl_pkg::REQ_APPEND: begin
                        if (!w_is_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_valid <= 1'b1;
                    end
                    btfl_pkg::REQ_LOOKUP: begin
                        r_valid <= (r_count == '0);
                    end
                    default: r_valid <= 1'b1;
                endcase
            end else if (r_state == S_FIN) begin
                r_valid <= 1'b1;
            end
        end
    end

    // lookup datapath and result fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found     <= 1'b0;
            r_best_idx  <= '0;
            r_best_chan <= '0;
            r_best_span <= '0;
            r_idx       <= '0;
            r_freq      <= i_query_freq;
            r_precise   <= i_precise_step;
            r_full      <= (i_req_type == btfl_pkg::REQ_APPEND) && w_is_full;
        end
        unique case (r_state)
            S_CHK: begin
                r_cand <= w_cand;
                r_span <= w_rentry.hi - w_rentry.lo;
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    r_cand <= (w_mod_rsp.rem == '0);
                end
            end
            S_UPD: begin
                if (w_better) begin
                    r_found     <= 1'b1;
                    r_best_span <= r_span;
                    r_best_idx  <= r_idx;
                    r_best_chan <= w_rentry.chan;
                end
                if (!w_last) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result ports, index and total keep their low bits
    assign w_idx_ext      = EXT_W'(r_best_idx);
    assign w_cnt_ext      = EXT_W'(r_count);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_band_index   = w_idx_ext[btfl_pkg::INDEX_W-1:0];
    assign o_band_channel = r_best_chan;
    assign o_table_full   = r_full;
    assign o_entry_total  = w_cnt_ext[btfl_pkg::TOTAL_W-1:0];

    // checks
    `BTFL_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_BANDS), "entry count above table size")
    `BTFL_ASSERT_IMPLY(a_hit_below_count, i_clk, i_rst_n, o_valid && o_found, CNT_W'(r_best_idx) < r_count, "chosen band outside table")
    `BTFL_ASSERT_IMPLY(a_mod_nonzero, i_clk, i_rst_n, w_mod_req.start, w_mod_req.divisor != '0, "remainder started with zero step")
    `BTFL_ASSERT_NEXT(a_fin_strobe, i_clk, i_rst_n, r_state == S_FIN, o_valid && !busy, "lookup end without result")
    `BTFL_ASSERT_NEXT(a_no_mid_strobe, i_clk, i_rst_n, busy && (r_state != S_FIN), !o_valid, "result during table walk")

endmodule

`default_nettype wire

@@ sv/btfl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module btfl_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/btfl_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module btfl_mod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire btfl_pkg::t_mod_req i_req,
    output btfl_pkg::t_mod_rsp     o_rsp
);

    localparam int DW    = btfl_pkg::FREQ_W;
    localparam int SW    = btfl_pkg::STEP_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_dvd;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_div;

    logic [SW:0]      w_trial;
    logic [SW:0]      w_diff;
    logic             w_ge;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

@@ verif/band_lookup_checker.sv @@
`timescale 1ns / 1ps

module band_lookup_checker
    import btfl_pkg::*;
#(
    parameter int MAX_BANDS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [FREQ_W-1:0]   i_band_start,
    input  logic [FREQ_W-1:0]   i_band_end,
    input  logic [STEP_W-1:0]   i_step_size,
    input  logic [CHAN_W-1:0]   i_channel_number,
    input  logic [FREQ_W-1:0]   i_query_freq,
    input  logic                i_precise_step,
    input  logic                i_valid,
    input  logic                i_found,
    input  logic [INDEX_W-1:0]  i_band_index,
    input  logic [CHAN_W-1:0]   i_band_channel,
    input  logic                i_table_full,
    input  logic [TOTAL_W-1:0]  i_entry_total,
    output int                  o_fail_count,
    output int                  o_pending
);

    // one answer of the block
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  chan;
        logic               full;
        logic [TOTAL_W-1:0] total;
    } t_answer;

    // local copy of the band table
    t_entry      bands [MAX_BANDS];
    int unsigned band_count = 0;

    t_answer     expected_answers [$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    // apply one request to the local table and work out its answer
    function automatic t_answer apply_band_request(
        input logic [REQ_W-1:0]  kind,
        input t_entry            fresh,
        input logic [FREQ_W-1:0] freq,
        input logic              precise
    );
        t_answer           ans;
        logic [FREQ_W-1:0] span;
        logic [FREQ_W-1:0] best_span;
        ans = '0;
        best_span = '0;
        case (kind)
            REQ_CLEAR: begin
                band_count = 0;
            end
            REQ_APPEND: begin
                if (band_count >= MAX_BANDS) begin
                    ans.full = 1'b1;
                end else begin
                    bands[band_count] = fresh;
                    band_count++;
                end
            end
            REQ_LOOKUP: begin
                for (int i = 0; i < band_count; i++) begin
                    // inverted bands contain nothing
                    if (freq < bands[i].lo || freq > bands[i].hi)
                        continue;
                    // precise mode needs a nonzero step dividing the frequency
                    if (precise && (bands[i].step == '0 || (freq % bands[i].step) != '0))
                        continue;
                    span = bands[i].hi - bands[i].lo;
                    // strict compare keeps the lowest index on equal spans
                    if (!ans.found || span < best_span) begin
                        ans.found = 1'b1;
                        best_span = span;
                        ans.index = INDEX_W'(i);
                        ans.chan  = bands[i].chan;
                    end
                end
            end
            default: ;
        endcase
        ans.total = TOTAL_W'(band_count);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input t_answer want, input t_answer seen);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected found=%0d index=%0d channel=%0d full=%0d total=%0d,",
                      " got found=%0d index=%0d channel=%0d full=%0d total=%0d"},
                     $time, what, want.found, want.index, want.chan, want.full, want.total,
                     seen.found, seen.index, seen.chan, seen.full, seen.total);
    endtask

    // results first, since a result at this edge belongs to an older request
    always @(posedge i_clk) begin
        t_answer seen;
        t_answer want;
        t_entry  fresh;
        if (i_rst_n) begin
            if (i_valid) begin
                seen.found = i_found;
                seen.index = i_band_index;
                seen.chan  = i_band_channel;
                seen.full  = i_table_full;
                seen.total = i_entry_total;
                if (expected_answers.size() == 0) begin
                    report_mismatch("result with no request waiting", '0, seen);
                end else begin
                    want = expected_answers.pop_front();
                    if (seen.found !== want.found || seen.index !== want.index ||
                        seen.chan !== want.chan || seen.full !== want.full ||
                        seen.total !== want.total)
                        report_mismatch("result mismatch", want, seen);
                end
            end
            // accepted request
            if (i_start && !i_busy) begin
                fresh.lo   = i_band_start;
                fresh.hi   = i_band_end;
                fresh.step = i_step_size;
                fresh.chan = i_channel_number;
                expected_answers.push_back(
                    apply_band_request(i_req_type, fresh, i_query_freq, i_precise_step));
            end
        end
        o_pending <= expected_answers.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import btfl_pkg::*;

    localparam int                TABLE_DEPTH = 32;
    localparam int                ITEM_TARGET = 650;
    localparam int                QUIET_AFTER = 560;
    localparam int unsigned       FREQ_TOP    = (1 << FREQ_W) - 1;
    localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type;
    logic [FREQ_W-1:0]   i_band_start;
    logic [FREQ_W-1:0]   i_band_end;
    logic [STEP_W-1:0]   i_step_size;
    logic [CHAN_W-1:0]   i_channel_number;
    logic [FREQ_W-1:0]   i_query_freq;
    logic                i_precise_step;
    logic                o_valid;
    logic                o_found;
    logic [INDEX_W-1:0]  o_band_index;
    logic [CHAN_W-1:0]   o_band_channel;
    logic                o_table_full;
    logic [TOTAL_W-1:0]  o_entry_total;
    int                  fail_count;
    int                  pending;

    // stimulus bookkeeping: bands the table should hold, for aiming lookups
    int unsigned shadow_lo [$];
    int unsigned shadow_hi [$];
    int unsigned shadow_step [$];
    int          issued = 0;
    int          gap_odds = 25;
    bit          quiet_tail = 1'b0;

    always #10 i_clk = ~i_clk;

    band_table_frequency_lookup #(
        .MAX_BANDS(TABLE_DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_band_start     (i_band_start),
        .i_band_end       (i_band_end),
        .i_step_size      (i_step_size),
        .i_channel_number (i_channel_number),
        .i_query_freq     (i_query_freq),
        .i_precise_step   (i_precise_step),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_band_index     (o_band_index),
        .o_band_channel   (o_band_channel),
        .o_table_full     (o_table_full),
        .o_entry_total    (o_entry_total)
    );

    band_lookup_checker #(
        .MAX_BANDS(TABLE_DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_req_type       (i_req_type),
        .i_band_start     (i_band_start),
        .i_band_end       (i_band_end),
        .i_step_size      (i_step_size),
        .i_channel_number (i_channel_number),
        .i_query_freq     (i_query_freq),
        .i_precise_step   (i_precise_step),
        .i_valid          (o_valid),
        .i_found          (o_found),
        .i_band_index     (o_band_index),
        .i_band_channel   (o_band_channel),
        .i_table_full     (o_table_full),
        .i_entry_total    (o_entry_total),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // drive one request and hold it until the block takes it
    task automatic issue_request(
        input logic [REQ_W-1:0] kind,
        input int unsigned      lo,
        input int unsigned      hi,
        input int unsigned      step,
        input int unsigned      chan,
        input int unsigned      freq,
        input logic             precise
    );
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 99) < gap_odds)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_req_type       <= kind;
        i_band_start     <= FREQ_W'(lo);
        i_band_end       <= FREQ_W'(hi);
        i_step_size      <= STEP_W'(step);
        i_channel_number <= CHAN_W'(chan);
        i_query_freq     <= FREQ_W'(freq);
        i_precise_step   <= precise;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
        if (issued >= QUIET_AFTER)
            quiet_tail = 1'b1;
        // keep the aiming list in step with the table
        if (kind == REQ_CLEAR) begin
            shadow_lo.delete();
            shadow_hi.delete();
            shadow_step.delete();
        end else if (kind == REQ_APPEND && shadow_lo.size() < TABLE_DEPTH) begin
            shadow_lo.push_back(lo & FREQ_TOP);
            shadow_hi.push_back(hi & FREQ_TOP);
            shadow_step.push_back(step & 32'hFFFF);
        end
    endtask

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 6))
            0: return 1;
            1: return 5;
            2: return 10;
            3: return 25;
            4: return 125;
            5: return 1000;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    // new band: nested in, around or beside a stored one, or fresh
    task automatic append_random_band();
        int unsigned lo;
        int unsigned hi;
        int unsigned width;
        int unsigned step;
        int unsigned k;
        int          sel;
        sel = $urandom_range(0, 9);
        step = ($urandom_range(0, 11) == 0) ? 0 : pick_step();
        if (sel < 4 && shadow_lo.size() > 0) begin
            k = $urandom_range(0, shadow_lo.size() - 1);
            lo = shadow_lo[k];
            hi = shadow_hi[k];
            if (lo <= hi) begin
                width = hi - lo;
                case ($urandom_range(0, 2))
                    0: begin
                        lo = lo + $urandom_range(0, width / 2);
                        hi = hi - $urandom_range(0, width / 2);
                    end
                    1: begin
                        lo = (lo > 1000) ? lo - $urandom_range(1, 1000) : 0;
                        hi = (hi < FREQ_TOP - 1000) ? hi + $urandom_range(1, 1000) : FREQ_TOP;
                    end
                    default: begin
                        // same span, shifted: ties on span
                        k = $urandom_range(0, width);
                        if (hi + k <= FREQ_TOP) begin
                            lo = lo + k;
                            hi = hi + k;
                        end
                    end
                endcase
            end
        end else if (sel < 6) begin
            lo = $urandom & FREQ_TOP;
            hi = $urandom & FREQ_TOP;
        end else begin
            lo = $urandom & FREQ_TOP;
            width = $urandom_range(0, 1 << $urandom_range(0, 20));
            hi = (lo + width > FREQ_TOP) ? FREQ_TOP : lo + width;
            if ($urandom_range(0, 9) == 0) begin
                width = lo;
                lo = hi + 1;
                hi = width;
            end
        end
        issue_request(REQ_APPEND, lo, hi, step, $urandom_range(0, 1023),
                      $urandom & FREQ_TOP, $urandom_range(0, 1));
    endtask

    // lookup aimed at the stored bands: inside, on and past the edges, on the step grid
    task automatic lookup_random();
        int unsigned lo;
        int unsigned hi;
        int unsigned step;
        int unsigned freq;
        int unsigned first;
        int unsigned last;
        int unsigned k;
        logic        precise;
        precise = $urandom_range(0, 1);
        if (shadow_lo.size() == 0 || $urandom_range(0, 99) < 15) begin
            freq = $urandom & FREQ_TOP;
        end else begin
            k = $urandom_range(0, shadow_lo.size() - 1);
            lo = shadow_lo[k];
            hi = shadow_hi[k];
            step = shadow_step[k];
            if (lo > hi) begin
                freq = $urandom_range(hi, lo);
            end else begin
                case ($urandom_range(0, 9))
                    0: freq = lo;
                    1: freq = hi;
                    2: freq = (lo > 0) ? lo - 1 : lo;
                    3: freq = (hi < FREQ_TOP) ? hi + 1 : hi;
                    4, 5, 6: begin
                        freq = $urandom_range(lo, hi);
                        if (step != 0) begin
                            first = (lo + step - 1) / step;
                            last = hi / step;
                            if (first <= last)
                                freq = $urandom_range(first, last) * step;
                            precise = ($urandom_range(0, 3) != 0);
                        end
                    end
                    default: freq = $urandom_range(lo, hi);
                endcase
            end
        end
        issue_request(REQ_LOOKUP, $urandom & FREQ_TOP, $urandom & FREQ_TOP, $urandom,
                      $urandom_range(0, 1023), freq, precise);
    endtask

    initial begin
        int pick;
        int count;
        int waited;

        start            <= 1'b0;
        i_rst_n          <= 1'b0;
        i_req_type       <= REQ_CLEAR;
        i_band_start     <= '0;
        i_band_end       <= '0;
        i_step_size      <= '0;
        i_channel_number <= '0;
        i_query_freq     <= '0;
        i_precise_step   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, field extremes, ties, zero step, inverted band
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 0, 1'b0);
        issue_request(REQ_APPEND, 0, FREQ_TOP, 1, 1023, 0, 1'b0);
        issue_request(REQ_APPEND, 1000, 2000, 25, 5, 0, 1'b0);
        issue_request(REQ_APPEND, 1000, 2000, 0, 7, 0, 1'b0);
        issue_request(REQ_APPEND, 5000, 4000, 1, 9, 0, 1'b0);
        issue_request(REQ_APPEND, 1500, 1500, 65535, 0, 0, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 0, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, FREQ_TOP, 1'b1);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 1000, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 1010, 1'b1);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 1025, 1'b1);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 1500, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 1500, 1'b1);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 4500, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 4500, 1'b1);
        issue_request(REQ_UNUSED, FREQ_TOP, FREQ_TOP, 65535, 1023, FREQ_TOP, 1'b1);
        issue_request(REQ_CLEAR, 0, 0, 0, 0, 0, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, 1500, 1'b0);
        issue_request(REQ_APPEND, FREQ_TOP, FREQ_TOP, 0, 512, 0, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, FREQ_TOP, 1'b0);
        issue_request(REQ_LOOKUP, 0, 0, 0, 0, FREQ_TOP, 1'b1);

        // random: mostly clear, a run of appends, then aimed lookups
        while (issued < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0: gap_odds = 0;
                1: gap_odds = 25;
                default: gap_odds = 50;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise request with random fields
                issue_request(($urandom_range(0, 19) == 0) ? REQ_UNUSED :
                              REQ_W'($urandom_range(0, 2)),
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 4) != 0)
                    issue_request(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom_range(0, 1));
                // now and then fill past the last slot
                count = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 35) :
                        $urandom_range(1, 8);
                repeat (count) append_random_band();
                repeat ($urandom_range(2, 10)) lookup_random();
            end
        end

        // drain, then allow for the longest lookup
        start <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (1000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
